>>> src/sq_pkg.sv
package sq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic signed [VALUE_W-1:0] EMPTY_POP_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     was_full;
        logic                     was_empty;
        logic signed [VALUE_W-1:0] popped_value;
    } result_t;

endpackage

>>> src/sq_mem.sv
module sq_mem #(
    parameter int DEPTH = sq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [sq_pkg::VALUE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [sq_pkg::VALUE_W-1:0]  rd_data
);
    import sq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sq_ctrl.sv
module sq_ctrl #(
    parameter int DEPTH = sq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sq_pkg::opcode_t             in_opcode,
    input  logic [sq_pkg::VALUE_W-1:0]  in_value,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sq_pkg::result_t             res,
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [sq_pkg::VALUE_W-1:0]  mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [sq_pkg::VALUE_W-1:0]  mem_rd_data
);
    import sq_pkg::*;

    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] ONE_A    = AW'(1);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    // Logical position to physical address in the circular buffer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[COUNT_OUT_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    result_t           res_reg, res_next;

    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] count_lo;
    logic [CW-1:0] count_inc;
    logic          rd_gt;
    logic          pos_last;

    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);
    assign count_lo  = count_reg[AW-1:0];
    assign count_inc = count_reg + ONE_C;
    assign rd_gt     = ($signed(mem_rd_data) > $signed(val_reg));
    assign pos_last  = ((CW'(pos_reg) + ONE_C) == count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_opcode)
                        OP_APPEND, OP_CLEAR: state_next = ST_EMIT;
                        OP_POP:    state_next = is_empty ? ST_EMIT : ST_POP;
                        OP_INSERT: state_next = (is_full || is_empty) ? ST_EMIT : ST_SEARCH;
                        default:   state_next = ST_EMIT;
                    endcase
                end
            end
            ST_POP:    state_next = ST_EMIT;
            ST_SEARCH: begin
                if (!rd_gt) begin
                    state_next = ST_SHIFT;
                end else if (pos_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_SHIFT: begin
                if (idx_reg == pos_reg) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = phys(head_reg, count_lo);
        mem_wr_data = val_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    val_next = in_value;
                    res_next = '{entry_count: count_out(count_reg), was_full: 1'b0,
                                 was_empty: 1'b0, popped_value: '0};
                    unique case (in_opcode)
                        OP_APPEND: begin
                            if (is_full) begin
                                res_next.was_full = 1'b1;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = in_value;
                                count_next  = count_inc;
                                res_next.entry_count = count_out(count_inc);
                            end
                        end
                        OP_INSERT: begin
                            if (is_full) begin
                                res_next.was_full = 1'b1;
                            end else if (is_empty) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = head_reg;
                                mem_wr_data = in_value;
                                count_next  = count_inc;
                                res_next.entry_count = count_out(count_inc);
                            end else begin
                                mem_rd_en = 1'b1;
                                pos_next  = '0;
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                res_next.popped_value = EMPTY_POP_VALUE;
                                res_next.was_empty    = 1'b1;
                            end else begin
                                mem_rd_en = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            head_next  = '0;
                            res_next.entry_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                res_next.popped_value = $signed(mem_rd_data);
                head_next  = phys(head_reg, ONE_A);
                count_next = count_reg - ONE_C;
                res_next.entry_count = count_out(count_reg - ONE_C);
            end
            ST_SEARCH: begin
                if (rd_gt) begin
                    if (pos_last) begin
                        mem_wr_en  = 1'b1;
                        count_next = count_inc;
                        res_next.entry_count = count_out(count_inc);
                    end else begin
                        pos_next    = pos_reg + ONE_A;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = phys(head_reg, pos_reg + ONE_A);
                    end
                end else begin
                    // Shift the tail up by one, starting from the last entry.
                    idx_next    = count_lo - ONE_A;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, count_lo - ONE_A);
                end
            end
            ST_SHIFT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, idx_reg + ONE_A);
                mem_wr_data = mem_rd_data;
                if (idx_reg != pos_reg) begin
                    idx_next    = idx_reg - ONE_A;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, idx_reg - ONE_A);
                end
            end
            ST_PLACE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, pos_reg);
                count_next  = count_inc;
                res_next.entry_count = count_out(count_inc);
            end
            ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

endmodule

>>> src/sorted_insert_queue.sv
// Ordered list of signed values held in a circular buffer memory. Ordered insert keeps the
// list descending; append adds at the tail unordered, and pop takes the head. An ordered insert
// reads entries in a walk, shifts the entries behind its place up and then writes the value,
// with one entry read and one entry write per cycle.
// One item is in work at a time: a new beat is taken only once the last one is through, and
// is taken while a result waits at the output. Reset (aresetn low, synchronous) empties the list.
module sorted_insert_queue #(
    parameter int DEPTH = sq_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_value[31:0]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // popped_value[31:0], was_empty[32], was_full[33], entry_count[38:34], zero pad[39]
    output logic [39:0] m_axis_tdata
);
    import sq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;

    logic    out_valid_reg;
    result_t out_data_reg;

    sq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (opcode_t'(s_axis_tuser)),
        .in_value    (s_axis_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    sq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The output register frees the controller as soon as a result is handed over.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

endmodule
